/* src/cvtl_pkg.sv */
// shared types, constants and helpers for the camera viewport transform with leash
package cvtl_pkg;

	// field and register widths
	localparam int COORD_W    = 32;
	localparam int MODE_W     = 2;
	localparam int VPW_W      = 14;
	localparam int ZOOM_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int NLANE      = 2;
	localparam int DIN_W      = 3 * COORD_W;
	localparam int DOUT_W     = 2 * COORD_W;

	// fixed point positions
	localparam int FRAC_W    = 16;
	localparam int HALF_SH   = 15;
	localparam int ZOOM_FRAC = 8;

	// serial unit widths
	localparam int MAG_W      = COORD_W + 1;
	localparam int PROD_W     = 2 * MAG_W;
	localparam int DVD_W      = MAG_W + COORD_W;
	localparam int DVS_W      = MAG_W;
	localparam int RAD_W      = PROD_W;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int RREM_W     = ROOT_W + 1;
	localparam int MUL_CNT_W  = $clog2(MAG_W);
	localparam int DIV_CNT_W  = $clog2(DVD_W);
	localparam int SQ_CNT_W   = $clog2(ROOT_W);

	// signed value before the final offset, and the sum after it
	localparam int VAL_W = 50;
	localparam int SUM_W = VAL_W + 1;

	// operating modes
	localparam logic [MODE_W-1:0] MODE_W2S   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_S2W   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LEASH = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VP_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VP_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZOOM      = 2'd2;

	// register reset values and zoom limits
	localparam logic [VPW_W-1:0]  VPW_RST  = 14'd640;
	localparam logic [VPW_W-1:0]  VPH_RST  = 14'd480;
	localparam logic [ZOOM_W-1:0] ZOOM_RST = 16'd8192;
	localparam logic [ZOOM_W-1:0] ZOOM_MIN = 16'd2048;
	localparam logic [ZOOM_W-1:0] ZOOM_MAX = 16'd32768;

	// status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_st_t;

	// saturate a wide signed sum to the coordinate range
	function automatic logic [COORD_W-1:0] sat_coord(input logic [SUM_W-1:0] v);
		logic pos_ovf;
		logic neg_ovf;
		pos_ovf = !v[SUM_W-1] && (|v[SUM_W-2:COORD_W-1]);
		neg_ovf = v[SUM_W-1] && !(&v[SUM_W-2:COORD_W-1]);
		if (pos_ovf) begin
			sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
		end else if (neg_ovf) begin
			sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			sat_coord = v[COORD_W-1:0];
		end
	endfunction

endpackage

/* src/camera_viewport_transform_leash_core.sv */
// top level: camera viewport transform and leash, sequencer and datapath
//
// One input item carries a mode in s_tuser and a point (or leash target and
// radius) in s_tdata; each item gives one result item on the master side.
// Mode 0 maps a world point to the screen, mode 1 maps a screen point to the
// world, mode 2 pulls the stored camera centre onto the leash circle and
// returns the new centre, mode 3 returns the centre unchanged.
// Items are handled one at a time. Mode 0 uses one 33-step serial multiply,
// mode 1 one 65-step serial divide, mode 2 a serial square and a 33-step
// square root, followed by a serial multiply and divide when the centre
// moves, and mode 3 none of the serial units.
// The result sits in an output register, so a new item is taken while the
// receiver stalls; a finished item waits only if that register is still full.
// Registers are written through the cfg port while the block is idle; the
// user must keep to this, since the block itself does not enforce it.
// Reset clears the centre to zero and loads viewport 640 x 480 and zoom 32.0.
module camera_viewport_transform_leash_core import cvtl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [DIN_W-1:0]      s_tdata,   // coord_q, coord_r, radius
	input  logic [MODE_W-1:0]     s_tuser,   // mode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [DOUT_W-1:0]     m_tdata    // result_q, result_r
);

	localparam int STATE_W = 4;
	localparam logic [STATE_W-1:0] ST_IDLE  = 4'd0;
	localparam logic [STATE_W-1:0] ST_ABS   = 4'd1;
	localparam logic [STATE_W-1:0] ST_MULGO = 4'd2;
	localparam logic [STATE_W-1:0] ST_MULW  = 4'd3;
	localparam logic [STATE_W-1:0] ST_SQGO  = 4'd4;
	localparam logic [STATE_W-1:0] ST_SQW   = 4'd5;
	localparam logic [STATE_W-1:0] ST_MRGO  = 4'd6;
	localparam logic [STATE_W-1:0] ST_MRW   = 4'd7;
	localparam logic [STATE_W-1:0] ST_DIVGO = 4'd8;
	localparam logic [STATE_W-1:0] ST_DIVW  = 4'd9;
	localparam logic [STATE_W-1:0] ST_SGN   = 4'd10;
	localparam logic [STATE_W-1:0] ST_ADD   = 4'd11;
	localparam logic [STATE_W-1:0] ST_OUT   = 4'd12;

	logic [STATE_W-1:0] state_q;
	logic [STATE_W-1:0] state_d;

	logic [VPW_W-1:0]   vpw_q;
	logic [VPW_W-1:0]   vph_q;
	logic [ZOOM_W-1:0]  zoom_q;

	logic [MODE_W-1:0]  mode_q;
	logic [COORD_W-1:0] radius_q;
	logic [COORD_W-1:0] center_q [NLANE];
	logic [COORD_W-1:0] tgt_q    [NLANE];
	logic [MAG_W-1:0]   diff_q   [NLANE];
	logic [MAG_W-1:0]   mag_q    [NLANE];
	logic [NLANE-1:0]   neg_q;
	logic signed [VAL_W-1:0] val_q [NLANE];
	logic [COORD_W-1:0] res_q    [NLANE];
	logic [MAG_W-1:0]   dist_q;
	logic [DOUT_W-1:0]  out_q;
	logic               ovalid_q;

	logic               accept;
	logic               load;
	logic               move;
	logic [COORD_W-1:0] coord_in [NLANE];
	logic [VPW_W-1:0]   half_px  [NLANE];
	logic [MAG_W-1:0]   half_ext [NLANE];
	logic [MAG_W-1:0]   mul_b    [NLANE];
	logic [PROD_W-1:0]  mul_prod [NLANE];
	logic [DVD_W-1:0]   dvd      [NLANE];
	logic [DVS_W-1:0]   dvs;
	logic [DVD_W-1:0]   quo      [NLANE];
	logic [RAD_W-1:0]   rad_sum;
	logic [ROOT_W-1:0]  root;
	logic [VAL_W-2:0]   sgn_mag  [NLANE];
	logic signed [VAL_W-1:0] term [NLANE];
	logic [VAL_W-1:0]   addend   [NLANE];
	logic [SUM_W-1:0]   sum      [NLANE];
	unit_st_t           mul_st   [NLANE];
	unit_st_t           div_st   [NLANE];
	unit_st_t           sq_st;

	// handshake
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign load     = !ovalid_q || m_tready;
	assign m_tvalid = ovalid_q;
	assign m_tdata  = out_q;

	// leash moves only when the distance is nonzero and beyond the radius
	assign move = (root != '0) && (root > {1'b0, radius_q});

	// lane inputs and screen offsets
	always_comb begin
		half_px[0] = vpw_q;
		half_px[1] = vph_q;
		for (int l = 0; l < NLANE; l++) begin
			coord_in[l] = s_tdata[l*COORD_W +: COORD_W];
			half_ext[l] = {{(MAG_W-VPW_W-HALF_SH){1'b0}}, half_px[l], {HALF_SH{1'b0}}};
		end
	end

	// operand selection for the serial units
	always_comb begin
		rad_sum = mul_prod[0] + mul_prod[1];
		dvs     = (mode_q == MODE_S2W) ? {{(DVS_W-ZOOM_W){1'b0}}, zoom_q} : dist_q;
		for (int l = 0; l < NLANE; l++) begin
			if (state_q == ST_MRGO) begin
				mul_b[l] = {1'b0, radius_q};
			end else if (mode_q == MODE_W2S) begin
				mul_b[l] = {{(MAG_W-ZOOM_W){1'b0}}, zoom_q};
			end else begin
				mul_b[l] = mag_q[l];
			end
			if (mode_q == MODE_S2W) begin
				dvd[l] = {{(DVD_W-MAG_W-ZOOM_FRAC){1'b0}}, mag_q[l], {ZOOM_FRAC{1'b0}}};
			end else begin
				dvd[l] = mul_prod[l][DVD_W-1:0];
			end
		end
	end

	// final offset and saturation
	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			sgn_mag[l] = (mode_q == MODE_W2S) ? mul_prod[l][VAL_W-2:0] : quo[l][VAL_W-2:0];
			term[l]    = (mode_q == MODE_W2S) ? (val_q[l] >>> ZOOM_FRAC) : val_q[l];
			case (mode_q)
				MODE_W2S: addend[l] = {{(VAL_W-MAG_W){1'b0}}, half_ext[l]};
				MODE_S2W: addend[l] = {{(VAL_W-COORD_W){center_q[l][COORD_W-1]}}, center_q[l]};
				default:  addend[l] = {{(VAL_W-COORD_W){tgt_q[l][COORD_W-1]}}, tgt_q[l]};
			endcase
			sum[l] = {term[l][VAL_W-1], term[l]} + {addend[l][VAL_W-1], addend[l]};
		end
	end

	// serial arithmetic units: a multiplier and a divider per axis, one shared square root
	for (genvar l = 0; l < NLANE; l++) begin : g_lane
		cvtl_mul u_mul (
			.clk    (clk),
			.arst_n (arst_n),
			.start  ((state_q == ST_MULGO) || (state_q == ST_MRGO)),
			.a      (mag_q[l]),
			.b      (mul_b[l]),
			.st     (mul_st[l]),
			.prod   (mul_prod[l])
		);

		cvtl_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (state_q == ST_DIVGO),
			.dividend (dvd[l]),
			.divisor  (dvs),
			.st       (div_st[l]),
			.quo      (quo[l])
		);
	end

	cvtl_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_SQGO),
		.rad    (rad_sum),
		.st     (sq_st),
		.root   (root)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_ABS;
			end
			ST_ABS: begin
				unique case (mode_q) inside
					MODE_W2S, MODE_LEASH: state_d = ST_MULGO;
					MODE_S2W:             state_d = ST_DIVGO;
					default:              state_d = ST_OUT;
				endcase
			end
			ST_MULGO: state_d = ST_MULW;
			ST_MULW: begin
				if (mul_st[0].done) state_d = (mode_q == MODE_W2S) ? ST_SGN : ST_SQGO;
			end
			ST_SQGO: state_d = ST_SQW;
			ST_SQW: begin
				if (sq_st.done) state_d = move ? ST_MRGO : ST_OUT;
			end
			ST_MRGO: state_d = ST_MRW;
			ST_MRW: begin
				if (mul_st[0].done) state_d = ST_DIVGO;
			end
			ST_DIVGO: state_d = ST_DIVW;
			ST_DIVW: begin
				if (div_st[0].done) state_d = ST_SGN;
			end
			ST_SGN: state_d = ST_ADD;
			ST_ADD: state_d = ST_OUT;
			ST_OUT: begin
				if (load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers, zoom clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpw_q  <= VPW_RST;
			vph_q  <= VPH_RST;
			zoom_q <= ZOOM_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_VP_WIDTH:  vpw_q <= cfg_data[VPW_W-1:0];
				REG_VP_HEIGHT: vph_q <= cfg_data[VPW_W-1:0];
				REG_ZOOM: begin
					if (cfg_data < ZOOM_MIN) begin
						zoom_q <= ZOOM_MIN;
					end else if (cfg_data > ZOOM_MAX) begin
						zoom_q <= ZOOM_MAX;
					end else begin
						zoom_q <= cfg_data;
					end
				end
				default: ;
			endcase
		end
	end

	// camera centre and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NLANE; l++) center_q[l] <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && load) begin
				ovalid_q <= 1'b1;
				if (mode_q == MODE_LEASH) begin
					for (int l = 0; l < NLANE; l++) center_q[l] <= res_q[l];
				end
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= s_tuser;
			radius_q <= s_tdata[2*COORD_W +: COORD_W];
			for (int l = 0; l < NLANE; l++) begin
				tgt_q[l] <= {coord_in[l][COORD_W-1:FRAC_W], {FRAC_W{1'b0}}};
				case (s_tuser)
					MODE_W2S: diff_q[l] <= {coord_in[l][COORD_W-1], coord_in[l]}
						- {center_q[l][COORD_W-1], center_q[l]};
					MODE_S2W: diff_q[l] <= {coord_in[l][COORD_W-1], coord_in[l]} - half_ext[l];
					default: diff_q[l] <= {center_q[l][COORD_W-1], center_q[l]}
						- {coord_in[l][COORD_W-1], coord_in[l][COORD_W-1:FRAC_W],
						{FRAC_W{1'b0}}};
				endcase
			end
		end
		// magnitude and sign; the centre is the default result
		if (state_q == ST_ABS) begin
			for (int l = 0; l < NLANE; l++) begin
				neg_q[l] <= diff_q[l][MAG_W-1];
				mag_q[l] <= diff_q[l][MAG_W-1] ? (~diff_q[l] + 1'b1) : diff_q[l];
				res_q[l] <= center_q[l];
			end
		end
		if (state_q == ST_SQW && sq_st.done) begin
			dist_q <= root;
		end
		// put the sign back on the magnitude
		if (state_q == ST_SGN) begin
			for (int l = 0; l < NLANE; l++) begin
				val_q[l] <= neg_q[l] ? $signed(~{1'b0, sgn_mag[l]} + 1'b1)
					: $signed({1'b0, sgn_mag[l]});
			end
		end
		if (state_q == ST_ADD) begin
			for (int l = 0; l < NLANE; l++) res_q[l] <= sat_coord(sum[l]);
		end
		if (state_q == ST_OUT && load) begin
			out_q <= {res_q[1], res_q[0]};
		end
	end

	// both axes run their serial units in lockstep
	assert property (@(posedge clk) disable iff (!arst_n)
		(mul_st[0].done == mul_st[1].done) && (div_st[0].done == div_st[1].done))
		else $error("axis units out of step");

	// a multiply finishes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_st[0].done |-> (state_q == ST_MULW || state_q == ST_MRW))
		else $error("multiply finished outside a wait state");

	// square root finishes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		sq_st.done |-> (state_q == ST_SQW))
		else $error("square root finished outside its wait state");

	// no serial unit is still running when a new item can be taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(mul_st[0].busy || mul_st[1].busy
		|| div_st[0].busy || div_st[1].busy || sq_st.busy))
		else $error("serial unit busy while idle");

	// the centre does not move on the cycle an item is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ($stable(center_q[0]) && $stable(center_q[1])))
		else $error("centre changed on item acceptance");

	// the centre only changes when a result is loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		(center_q[0] != $past(center_q[0]) || center_q[1] != $past(center_q[1]))
		|-> ($past(state_q) == ST_OUT))
		else $error("centre changed outside result load");

endmodule

/* src/cvtl_mul.sv */
// bit-serial unsigned multiplier, one multiplier bit per cycle
module cvtl_mul import cvtl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MAG_W-1:0]  a,
	input  logic [MAG_W-1:0]  b,
	output unit_st_t          st,
	output logic [PROD_W-1:0] prod
);

	logic [PROD_W-1:0]    acc_q;
	logic [MAG_W-1:0]     a_q;
	logic [MAG_W-1:0]     b_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [MAG_W:0]       sum;

	// add the multiplicand into the upper half when the current bit is set
	always_comb begin
		sum = {1'b0, acc_q[PROD_W-1:MAG_W]} + (b_q[0] ? {1'b0, a_q} : {(MAG_W+1){1'b0}});
	end

	// step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= MUL_CNT_W'(MAG_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// accumulator shifts right as multiplier bits are consumed
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[MAG_W-1:1]};
			b_q   <= {1'b0, b_q[MAG_W-1:1]};
		end
	end

	assign st.busy = busy_q;
	assign st.done = done_q;
	assign prod    = acc_q;

endmodule

/* src/cvtl_div.sv */
// restoring divider, one quotient bit per cycle
module cvtl_div import cvtl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output unit_st_t         st,
	output logic [DVD_W-1:0] quo
);

	logic [DVS_W-1:0]     rem_q;
	logic [DVD_W-1:0]     quo_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DVS_W:0]       shifted;
	logic [DVS_W+1:0]     trial;
	logic                 ge;

	// trial subtraction of the divisor from the partial remainder
	always_comb begin
		shifted = {rem_q, quo_q[DVD_W-1]};
		trial   = {1'b0, shifted} - {2'b00, dvs_q};
		ge      = !trial[DVS_W+1];
	end

	// step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= DIV_CNT_W'(DVD_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits leave at the top as quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign st.busy = busy_q;
	assign st.done = done_q;
	assign quo     = quo_q;

endmodule

/* src/cvtl_sqrt.sv */
// digit-by-digit floor square root, two radicand bits per cycle
module cvtl_sqrt import cvtl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  rad,
	output unit_st_t          st,
	output logic [ROOT_W-1:0] root
);

	logic [RAD_W-1:0]    rad_q;
	logic [RREM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [SQ_CNT_W-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [RREM_W+1:0]   rem_sh;
	logic [RREM_W+2:0]   trial;
	logic                ge;

	// bring in the next bit pair and try the candidate 4r+1
	always_comb begin
		rem_sh = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
		trial  = {1'b0, rem_sh} - {2'b00, root_q, 2'b01};
		ge     = !trial[RREM_W+2];
	end

	// step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= SQ_CNT_W'(ROOT_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// radicand shifts out two bits a step, root grows one bit a step
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? trial[RREM_W-1:0] : rem_sh[RREM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign st.busy = busy_q;
	assign st.done = done_q;
	assign root    = root_q;

endmodule
